### rtl/hpq_pkg.sv
package hpq_pkg;

  // Default sizing
  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 32;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_MIN_FIRST   = 1'd0;
  localparam logic [0:0] REG_SIGNED_KEYS = 1'd1;

  // Operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
  } item_t;

  typedef struct packed {
    logic [31:0] out_key;
    logic [1:0]  status;
    logic [8:0]  count_after;
    logic [31:0] top_key;
    logic        top_valid;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       up_init;
    logic       up_rd;
    logic       up_move;
    logic       dn_init;
    logic       dn_last;
    logic       dn_move;
    logic       fin_write;
    logic       cnt_inc;
    logic       finish;
    logic [1:0] code;
    logic       give_key;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_op;
    logic op;
    logic full;
    logic empty;
    logic count_one;
    logic parent_zero;
    logic up_swap;
    logic dn_first;
    logic dn_swap;
    logic dn_more;
  } stat_t;

endpackage

### rtl/hpq_ram.sv
module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### rtl/hpq_ctrl.sv
module hpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  hpq_pkg::stat_t st,
  output hpq_pkg::cmd_t  cmd,
  output logic           busy
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_LAST = 3'd3;
  localparam logic [2:0] S_DN_CMP  = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  // Sequence one operation
  always_comb begin
    cmd        = '0;
    cmd.code   = hpq_pkg::ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (st.in_op == hpq_pkg::OP_INSERT) begin
            if (st.full) begin
              cmd.finish = 1'b1;
              cmd.code   = hpq_pkg::ST_FULL;
            end else begin
              cmd.up_init = 1'b1;
              state_next  = st.empty ? S_FIN : S_UP_RD;
            end
          end else begin
            if (st.empty) begin
              cmd.finish = 1'b1;
              cmd.code   = hpq_pkg::ST_EMPTY;
            end else begin
              cmd.dn_init = 1'b1;
              if (st.count_one) begin
                cmd.finish   = 1'b1;
                cmd.give_key = 1'b1;
              end else begin
                state_next = S_DN_LAST;
              end
            end
          end
        end
      end
      S_UP_RD: begin
        cmd.up_rd  = 1'b1;
        state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (st.up_swap) begin
          cmd.up_move = 1'b1;
          state_next  = st.parent_zero ? S_FIN : S_UP_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DN_LAST: begin
        cmd.dn_last = 1'b1;
        state_next  = st.dn_first ? S_DN_CMP : S_FIN;
      end
      S_DN_CMP: begin
        if (st.dn_swap) begin
          cmd.dn_move = 1'b1;
          state_next  = st.dn_more ? S_DN_CMP : S_FIN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin_write = 1'b1;
        cmd.cnt_inc   = (st.op == hpq_pkg::OP_INSERT);
        cmd.give_key  = (st.op == hpq_pkg::OP_EXTRACT);
        cmd.finish    = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/hpq_dp.sv
module hpq_dp #(
  parameter int CAPACITY = hpq_pkg::CAPACITY,
  parameter int KEY_BITS = hpq_pkg::KEY_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             min_first,
  input  logic             signed_keys,
  input  hpq_pkg::item_t   item,
  input  hpq_pkg::cmd_t    cmd,
  output hpq_pkg::stat_t   st,
  output hpq_pkg::result_t result,
  output logic             result_valid
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  // True when a must sit strictly above b
  function automatic logic outranks(input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b,
                                    input logic minf,
                                    input logic sgn);
    logic [KEY_BITS-1:0] flip;
    logic [KEY_BITS-1:0] fa;
    logic [KEY_BITS-1:0] fb;
    flip           = '0;
    flip[KEY_BITS-1] = sgn;
    fa             = a ^ flip;
    fb             = b ^ flip;
    return minf ? (fa < fb) : (fa > fb);
  endfunction

  logic [KEY_BITS-1:0] cur;
  logic [KEY_BITS-1:0] top;
  logic [KEY_BITS-1:0] got;
  logic [AW-1:0]       pos;
  logic [CW-1:0]       count;
  logic                op_q;

  logic [KEY_BITS-1:0] top_next;
  logic [KEY_BITS-1:0] got_next;
  logic [CW-1:0]       count_next;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic [AW-1:0]       rd_addr_a;
  logic [AW-1:0]       rd_addr_b;
  logic [KEY_BITS-1:0] rd_data_a;
  logic [KEY_BITS-1:0] rd_data_b;

  logic [KEY_BITS+31:0] key_wide;
  logic [KEY_BITS-1:0]  in_key;
  logic [KEY_BITS+31:0] got_wide;
  logic [KEY_BITS+31:0] top_wide;
  logic [CW+8:0]        count_wide;

  logic [AW-1:0]       parent;
  logic [IW-1:0]       left;
  logic [IW-1:0]       right;
  logic                right_ok;
  logic                take_right;
  logic [IW-1:0]       best_idx;
  logic [KEY_BITS-1:0] best_val;
  logic [IW-1:0]       next_left;
  logic [IW-1:0]       next_right;

  hpq_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  // Fit the key field to the stored width
  assign key_wide = {{KEY_BITS{1'b0}}, item.key};
  assign in_key   = key_wide[KEY_BITS-1:0];

  // Tree neighbors of the hole
  assign parent     = AW'((pos - AW'(1)) >> 1);
  assign left       = {1'b0, pos, 1'b1};
  assign right      = left + IW'(1);
  assign right_ok   = right < IW'(count);
  assign take_right = right_ok && outranks(rd_data_b, rd_data_a, min_first, signed_keys);
  assign best_idx   = take_right ? right : left;
  assign best_val   = take_right ? rd_data_b : rd_data_a;
  assign next_left  = {1'b0, best_idx[AW-1:0], 1'b1};
  assign next_right = next_left + IW'(1);

  // Status toward the controller
  always_comb begin
    st             = '0;
    st.in_op       = item.op;
    st.op          = op_q;
    st.full        = (count == CW'(CAPACITY));
    st.empty       = (count == '0);
    st.count_one   = (count == CW'(1));
    st.parent_zero = (parent == '0);
    st.up_swap     = outranks(cur, rd_data_a, min_first, signed_keys);
    st.dn_first    = (count >= CW'(2));
    st.dn_swap     = outranks(best_val, cur, min_first, signed_keys);
    st.dn_more     = (next_left < IW'(count));
  end

  // Steer memory ports
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = pos;
    wr_data   = cur;
    rd_addr_a = parent;
    rd_addr_b = '0;
    if (cmd.up_move) begin
      wr_en   = 1'b1;
      wr_data = rd_data_a;
    end
    if (cmd.dn_move) begin
      wr_en   = 1'b1;
      wr_data = best_val;
    end
    if (cmd.fin_write) begin
      wr_en = 1'b1;
    end
    if (cmd.dn_init) begin
      rd_addr_a = AW'(count - CW'(1));
    end
    if (cmd.dn_last) begin
      rd_addr_a = AW'(1);
      rd_addr_b = AW'(2);
    end
    if (cmd.dn_move) begin
      rd_addr_a = next_left[AW-1:0];
      rd_addr_b = next_right[AW-1:0];
    end
  end

  // Next values seen by the result
  always_comb begin
    top_next   = (wr_en && (wr_addr == '0)) ? wr_data : top;
    got_next   = cmd.dn_init ? top : got;
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + CW'(1);
    end
    if (cmd.dn_init) begin
      count_next = count - CW'(1);
    end
  end

  assign got_wide   = {32'd0, got_next};
  assign top_wide   = {32'd0, top_next};
  assign count_wide = {9'd0, count_next};

  // Hold count and handshake state
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      count        <= count_next;
      result_valid <= cmd.finish;
    end
  end

  // Advance the working registers
  always_ff @(posedge clk) begin
    top <= top_next;
    got <= got_next;
    if (cmd.load) begin
      op_q <= item.op;
      cur  <= in_key;
    end
    if (cmd.up_init) begin
      pos <= count[AW-1:0];
    end
    if (cmd.up_move) begin
      pos <= parent;
    end
    if (cmd.dn_last) begin
      cur <= rd_data_a;
      pos <= '0;
    end
    if (cmd.dn_move) begin
      pos <= best_idx[AW-1:0];
    end
    if (cmd.finish) begin
      result.out_key     <= cmd.give_key ? got_wide[31:0] : 32'd0;
      result.status      <= cmd.code;
      result.count_after <= count_wide[8:0];
      result.top_key     <= (count_next != '0) ? top_wide[31:0] : 32'd0;
      result.top_valid   <= (count_next != '0);
    end
  end

endmodule

### rtl/binary_heap_priority_queue.sv
// Channel   Handshake            Payload                    Beat taken when
// item      start / busy         hpq_pkg::item_t (op, key)  start && !busy at clk edge
// result    result_valid         hpq_pkg::result_t          every cycle result_valid is high
// config    psel/penable/pwrite  pwdata[0] at paddr 0 / 4   psel && penable && pwrite
//
// Insert reads and compares each parent in S_UP_RD and S_UP_CMP, then writes in S_FIN;
// extract loads the last key in S_DN_LAST, compares each child pair in S_DN_CMP, then S_FIN.
// Each compare waits on the registered read of the key memory, visited once per level.
// Full/empty cases and extract of the last key report in the cycle after accept.
// Synchronous reset empties the queue and clears both registers; memory is not swept.
// Results cannot be stalled; the next item may start in the cycle a result shows.
module binary_heap_priority_queue #(
  parameter int CAPACITY = hpq_pkg::CAPACITY,
  parameter int KEY_BITS = hpq_pkg::KEY_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  hpq_pkg::item_t             item,
  output hpq_pkg::result_t           result,
  output logic                       result_valid,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic           min_first;
  logic           signed_keys;
  hpq_pkg::cmd_t  cmd;
  hpq_pkg::stat_t st;
  logic [0:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[hpq_pkg::ADDR_W-1];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_first   <= 1'b0;
      signed_keys <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        hpq_pkg::REG_MIN_FIRST:   min_first   <= pwdata[0];
        hpq_pkg::REG_SIGNED_KEYS: signed_keys <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    case (reg_idx)
      hpq_pkg::REG_MIN_FIRST:   prdata = {31'd0, min_first};
      hpq_pkg::REG_SIGNED_KEYS: prdata = {31'd0, signed_keys};
      default:                  prdata = 32'd0;
    endcase
  end

  hpq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .st   (st),
    .cmd  (cmd),
    .busy (busy)
  );

  hpq_dp #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .min_first   (min_first),
    .signed_keys (signed_keys),
    .item        (item),
    .cmd         (cmd),
    .st          (st),
    .result      (result),
    .result_valid(result_valid)
  );

endmodule

### rtl/hpq_checker.sv
module hpq_checker (
  input logic             clk,
  input logic             rst,
  input logic             busy,
  input hpq_pkg::result_t result,
  input logic             result_valid
);

  // Reset leaves the block idle with no beat pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("busy or result after reset");

  // Top flag follows the count
  a_top_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.top_valid == (result.count_after != 9'd0))
    else $error("top_valid disagrees with count_after");

  // Failed operations return no key
  a_fail_key: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != hpq_pkg::ST_OK) |-> result.out_key == 32'd0)
    else $error("key returned on failed operation");

  // Empty extract reports an empty queue
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == hpq_pkg::ST_EMPTY)
      |-> (result.count_after == 9'd0) && !result.top_valid)
    else $error("empty status with keys stored");

  // Full insert reports a nonempty queue
  a_full_top: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == hpq_pkg::ST_FULL) |-> result.top_valid)
    else $error("full status with empty queue");

endmodule

bind binary_heap_priority_queue hpq_checker u_hpq_checker (.*);

### tb/tb_binary_heap_priority_queue.sv
module tb_binary_heap_priority_queue;
  import hpq_pkg::*;

  localparam int MAX_GAP = 20;
  localparam int N_DIRECTED = 22;

  // One row of the directed table; res is only used where typed is set
  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } step_t;

  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{'{OP_EXTRACT, 32'h0000_0000}, 1'b1, '{32'h0, ST_EMPTY, 9'd0, 32'h0, 1'b0}},
    '{'{OP_INSERT,  32'h0000_0000}, 1'b1, '{32'h0, ST_OK, 9'd1, 32'h0, 1'b1}},
    '{'{OP_INSERT,  32'hFFFF_FFFF}, 1'b1, '{32'h0, ST_OK, 9'd2, 32'hFFFF_FFFF, 1'b1}},
    '{'{OP_INSERT,  32'h8000_0000}, 1'b1, '{32'h0, ST_OK, 9'd3, 32'hFFFF_FFFF, 1'b1}},
    '{'{OP_INSERT,  32'h7FFF_FFFF}, 1'b0, '0},
    '{'{OP_INSERT,  32'h7FFF_FFFF}, 1'b0, '0},
    '{'{OP_INSERT,  32'h0000_0001}, 1'b0, '0},
    '{'{OP_INSERT,  32'h8000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT, 32'hDEAD_BEEF}, 1'b1,
      '{32'hFFFF_FFFF, ST_OK, 9'd6, 32'h8000_0000, 1'b1}},
    '{'{OP_EXTRACT, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OP_EXTRACT, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT, 32'h1234_5678}, 1'b1, '{32'h0, ST_EMPTY, 9'd0, 32'h0, 1'b0}},
    '{'{OP_INSERT,  32'h0000_0005}, 1'b1, '{32'h0, ST_OK, 9'd1, 32'h5, 1'b1}},
    '{'{OP_INSERT,  32'h0000_0005}, 1'b0, '0},
    '{'{OP_INSERT,  32'h0000_0006}, 1'b0, '0},
    '{'{OP_EXTRACT, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT, 32'h0000_0000}, 1'b1, '{32'h5, ST_OK, 9'd0, 32'h0, 1'b0}}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  item_t             op_item = '0;
  result_t           reply;
  logic              reply_valid;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow copy of the queue contents and settings
  logic [31:0] heap_keys [CAPACITY];
  int unsigned heap_len = 0;
  bit          order_min = 1'b0;
  bit          keys_signed = 1'b0;

  result_t     owed_results[$];
  int          fail_count = 0;

  binary_heap_priority_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (op_item),
    .result       (reply),
    .result_valid (reply_valid),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // True when key a belongs strictly above key b under the current order
  function automatic bit ranks_above(logic [31:0] a, logic [31:0] b);
    if (keys_signed) begin
      a[31] = ~a[31];
      b[31] = ~b[31];
    end
    return order_min ? (a < b) : (a > b);
  endfunction

  function automatic void swap_keys(int unsigned i, int unsigned j);
    logic [31:0] t;
    t = heap_keys[i];
    heap_keys[i] = heap_keys[j];
    heap_keys[j] = t;
  endfunction

  // Apply one operation to the shadow queue and return the reply it earns
  function automatic result_t apply_heap_op(item_t it);
    result_t     r;
    int unsigned pos;
    int unsigned up;
    int unsigned lc;
    int unsigned best;
    r = '0;
    if (it.op == OP_INSERT) begin
      if (heap_len >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_keys[heap_len] = it.key;
        pos = heap_len;
        heap_len++;
        // sift up while strictly better than the parent
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (!ranks_above(heap_keys[pos], heap_keys[up])) break;
          swap_keys(pos, up);
          pos = up;
        end
      end
    end else if (heap_len == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.out_key = heap_keys[0];
      heap_len--;
      heap_keys[0] = heap_keys[heap_len];
      pos = 0;
      // sift down; left child wins a tie, a lone left child still counts
      forever begin
        lc = 2 * pos + 1;
        if (lc >= heap_len) break;
        best = lc;
        if (lc + 1 < heap_len && ranks_above(heap_keys[lc + 1], heap_keys[lc])) best = lc + 1;
        if (!ranks_above(heap_keys[best], heap_keys[pos])) break;
        swap_keys(pos, best);
        pos = best;
      end
    end
    r.status      = r.status;
    r.count_after = 9'(heap_len);
    r.top_valid   = (heap_len != 0);
    r.top_key     = (heap_len != 0) ? heap_keys[0] : 32'h0;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each reply beat against the oldest owed result
  always @(posedge clk) begin : check_replies
    result_t want;
    if (!rst && reply_valid) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected reply, expected none, got %h", $time, reply);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        check_field("out_key", want.out_key, reply.out_key);
        check_field("status", 32'(want.status), 32'(reply.status));
        check_field("count_after", 32'(want.count_after), 32'(reply.count_after));
        check_field("top_key", want.top_key, reply.top_key);
        check_field("top_valid", 32'(want.top_valid), 32'(reply.top_valid));
      end
    end
  end

  function automatic int idle_gap(int pct);
    int g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  // Hold start until the beat is taken, then idle for gap cycles
  task automatic send_item(item_t it, bit typed, result_t typed_res, int gap);
    result_t predicted;
    start   <= 1'b1;
    op_item <= it;
    do @(posedge clk); while (busy);
    predicted = apply_heap_op(it);
    owed_results.push_back(typed ? typed_res : predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait for every owed result and for the block to go idle
  task automatic wait_drained();
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, bit value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MIN_FIRST) order_min = value;
    else keys_signed = value;
  endtask

  task automatic set_order(bit min_first, bit signed_keys);
    wait_drained();
    write_reg(REG_MIN_FIRST, min_first);
    // leave the bus idle between the two transfers
    @(posedge clk);
    write_reg(REG_SIGNED_KEYS, signed_keys);
  endtask

  // Mix of full random, tiny (duplicate-heavy), extreme and sign-boundary keys
  function automatic logic [31:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(7));
      2: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return 32'h8000_0000 ^ 32'($urandom_range(7));
    endcase
  endfunction

  // Random ops; insert bias swings so the fill level wanders up and down
  task automatic run_mix(int n, int idle_pct);
    item_t it;
    int    ins_pct;
    int    pct;
    for (int i = 0; i < n; i++) begin
      ins_pct = ((i / 64) % 2 == 0) ? 70 : 30;
      pct     = ((i / 40) % 4 == 3) ? 0 : idle_pct;
      it.op   = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_EXTRACT;
      it.key  = pick_key();
      send_item(it, 1'b0, '0, idle_gap(pct));
    end
  endtask

  // Fill to capacity, push past full, then drain past empty
  task automatic fill_and_drain(int idle_pct);
    item_t it;
    it.op = OP_INSERT;
    while (heap_len < CAPACITY) begin
      it.key = pick_key();
      send_item(it, 1'b0, '0, idle_gap(idle_pct));
    end
    repeat (8) begin
      it.key = pick_key();
      send_item(it, 1'b0, '0, idle_gap(idle_pct));
    end
    it.op = OP_EXTRACT;
    while (heap_len > 0) begin
      it.key = $urandom;
      send_item(it, 1'b0, '0, idle_gap(idle_pct));
    end
    repeat (4) begin
      it.key = $urandom;
      send_item(it, 1'b0, '0, idle_gap(idle_pct));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_order(1'b0, 1'b0);
    foreach (DIRECTED[i]) send_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].res, 0);

    run_mix(350, 0);
    // order flips with keys still stored
    set_order(1'b1, 1'b1);
    run_mix(350, 48);
    set_order(1'b1, 1'b0);
    fill_and_drain(0);
    set_order(1'b0, 1'b1);
    run_mix(350, 36);
    set_order(1'b0, 1'b0);
    run_mix(300, 48);

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
